[src/assert_macros.svh]
// Assertion helpers used by the ring buffer unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ORBC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("orbc assertion failed");

// Condition that must never be seen outside reset.
`define ORBC_NEVER(lbl, clk, rst_n, cond) \
	`ORBC_ASSERT(lbl, clk, rst_n, !(cond))

`endif

[src/orbc_pkg.sv]
`default_nettype none
package orbc_pkg;

	localparam int unsigned CAP_W    = 11;
	localparam int unsigned POS_W    = 11;
	localparam int unsigned CURSOR_W = 10;
	localparam int unsigned STEP_W   = 12;
	localparam int unsigned PORT_W   = 64;
	localparam int unsigned CAP_MAX  = 2047;

	typedef enum logic [1:0] {
		ACT_PUSH = 2'd0,
		ACT_BACK = 2'd1,
		ACT_FWD  = 2'd2,
		ACT_MOVE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_REFUSED   = 2'd1,
		ST_OVERWRITE = 2'd2
	} status_t;

endpackage
`default_nettype wire

[src/orbc_ifs.sv]
`default_nettype none

// Request channel: one word per action.
interface orbc_req_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             action;
	logic [orbc_pkg::PORT_W-1:0]            sample_word;
	logic [orbc_pkg::CURSOR_W-1:0]          cursor;
	logic signed [orbc_pkg::STEP_W-1:0]     step;

	modport source (output valid, action, sample_word, cursor, step, input ready);
	modport sink   (input valid, action, sample_word, cursor, step, output ready);
endinterface

// Response channel: one word per accepted request.
interface orbc_rsp_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             status;
	logic [orbc_pkg::PORT_W-1:0]            read_word;
	logic [orbc_pkg::CURSOR_W-1:0]          new_cursor;

	modport source (output valid, status, read_word, new_cursor, input ready);
	modport sink   (input valid, status, read_word, new_cursor, output ready);
endinterface

// Configuration channel carrying the capacity register.
interface orbc_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [orbc_pkg::CAP_W-1:0]             data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[src/overwriting_ring_buffer_with_cursor_unit.sv]
// Overwriting ring buffer of sample words with a caller-held read cursor.
// Channels: req carries one request word (action, sample_word, cursor, step),
// rsp returns one response word (status, read_word, new_cursor) per request,
// cfg writes the capacity register. All use valid/ready; a word moves at a
// rising clock edge with valid and ready both high.
// A push writes the sample at the write position; when the ring is full the
// oldest sample is dropped and status reports the overwrite. Back and forward
// step the cursor one place and return the word found there, unless refused at
// the end of the ring. Move shifts the cursor by a signed step, wrapping at capacity.
// A response passes through the middle stage and then the output register; the
// single-port sample memory is accessed at the accept edge and its registered
// read data is captured into the output register when the middle stage advances.
// Throughput: one request per cycle while responses are taken, set by the one
// memory access per request. A stalled receiver backs up the output register
// and then the middle stage; req.ready drops only once both are full.
// Reset clears the positions and count and sets capacity to DEPTH (limited to
// the register's range). Memory contents stay undefined until written, and a
// capacity write empties the ring. Configuration is accepted in any cycle but
// is meant to be written only while no request is in flight.
`default_nettype none
`include "assert_macros.svh"
module overwriting_ring_buffer_with_cursor_unit #(
	parameter int unsigned DEPTH     = 1024,
	parameter int unsigned WORD_BITS = 64
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	orbc_req_if.sink    req,
	orbc_rsp_if.source  rsp,
	orbc_cfg_if.sink    cfg
);

	localparam int unsigned AW      = $clog2(DEPTH);
	localparam int unsigned POS_W   = orbc_pkg::POS_W;
	localparam int unsigned STEP_W  = orbc_pkg::STEP_W;
	localparam int unsigned CAP_RST = (DEPTH > orbc_pkg::CAP_MAX) ? orbc_pkg::CAP_MAX : DEPTH;

	// Ring state. cap_q holds the effective capacity, already clamped.
	logic [orbc_pkg::CAP_W-1:0] cap_q;
	logic [POS_W-1:0]           oldest_q;
	logic [POS_W-1:0]           newest_q;
	logic [POS_W-1:0]           write_q;
	logic [orbc_pkg::CAP_W-1:0] fill_q;

	// Middle stage: waits for the memory read data.
	logic                       valid_s1;
	orbc_pkg::status_t          status_s1;
	logic [orbc_pkg::CURSOR_W-1:0] ncur_s1;
	logic                       rd_s1;

	// Output register.
	logic                       out_valid_q;
	orbc_pkg::status_t          out_status_q;
	logic [orbc_pkg::PORT_W-1:0] out_word_q;
	logic [orbc_pkg::CURSOR_W-1:0] out_cursor_q;

	logic accept;
	logic advance;
	logic cfg_wr;

	orbc_pkg::action_t act;
	logic [POS_W-1:0]  cur_ext;
	logic [POS_W-1:0]  pos;
	logic [POS_W-1:0]  pos_inc;
	logic [POS_W-1:0]  pos_dec;
	logic [POS_W-1:0]  write_inc;
	logic [POS_W-1:0]  oldest_inc;
	logic [STEP_W-1:0] cap_ext;
	logic [STEP_W-1:0] mag;
	logic [STEP_W-1:0] sum;
	logic [STEP_W-1:0] sum_wrap;
	logic [POS_W-1:0]  ncur;
	logic              full;
	logic              do_read;
	orbc_pkg::status_t status_d;

	logic              mem_en;
	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	logic [WORD_BITS-1:0] mem_rdata;

	// The middle stage empties whenever the output register is free or drained.
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid;

	always_comb begin
		act        = orbc_pkg::action_t'(req.action);
		cur_ext    = POS_W'(req.cursor);
		// A cursor outside the ring is pulled back to its last slot.
		pos        = (cur_ext >= cap_q) ? (cap_q - 1'b1) : cur_ext;
		pos_inc    = ((pos + 1'b1) >= cap_q) ? '0 : (pos + 1'b1);
		pos_dec    = (pos == '0) ? (cap_q - 1'b1) : (pos - 1'b1);
		write_inc  = ((write_q + 1'b1) >= cap_q) ? '0 : (write_q + 1'b1);
		oldest_inc = ((oldest_q + 1'b1) >= cap_q) ? '0 : (oldest_q + 1'b1);
		full       = (fill_q >= cap_q);

		cap_ext = STEP_W'(cap_q);
		mag     = req.step[STEP_W-1] ? $unsigned(-req.step) : $unsigned(req.step);
		// Both directions land below twice the capacity, so one subtract wraps.
		if (req.step[STEP_W-1]) begin
			sum = STEP_W'(pos) + cap_ext - mag;
		end else begin
			sum = STEP_W'(pos) + mag;
		end
		sum_wrap = (sum >= cap_ext) ? (sum - cap_ext) : sum;

		status_d = orbc_pkg::ST_OK;
		ncur     = cur_ext;
		do_read  = 1'b0;
		case (act)
			orbc_pkg::ACT_PUSH: begin
				if (full) begin
					status_d = orbc_pkg::ST_OVERWRITE;
				end
			end
			orbc_pkg::ACT_BACK: begin
				if (fill_q == '0 || pos == oldest_q) begin
					status_d = orbc_pkg::ST_REFUSED;
				end else begin
					ncur    = pos_dec;
					do_read = 1'b1;
				end
			end
			orbc_pkg::ACT_FWD: begin
				if (fill_q == '0 || pos == newest_q) begin
					status_d = orbc_pkg::ST_REFUSED;
				end else begin
					ncur    = pos_inc;
					do_read = 1'b1;
				end
			end
			orbc_pkg::ACT_MOVE: begin
				if (req.step != '0 && mag <= cap_ext) begin
					ncur = sum_wrap[POS_W-1:0];
				end
			end
			default: begin
				status_d = orbc_pkg::ST_OK;
			end
		endcase

		mem_en   = accept && (act == orbc_pkg::ACT_PUSH || do_read);
		mem_we   = (act == orbc_pkg::ACT_PUSH);
		mem_addr = mem_we ? AW'(write_q) : AW'(ncur);
	end

	orbc_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (req.sample_word[WORD_BITS-1:0]),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= orbc_pkg::CAP_W'(CAP_RST);
			oldest_q <= '0;
			newest_q <= '0;
			write_q  <= '0;
			fill_q   <= '0;
		end else if (cfg_wr) begin
			// Clamp once here: zero acts as one, anything above DEPTH as DEPTH.
			if (cfg.data == '0) begin
				cap_q <= orbc_pkg::CAP_W'(1);
			end else if (32'(cfg.data) > DEPTH) begin
				cap_q <= orbc_pkg::CAP_W'(CAP_RST);
			end else begin
				cap_q <= cfg.data;
			end
			oldest_q <= '0;
			newest_q <= '0;
			write_q  <= '0;
			fill_q   <= '0;
		end else if (accept && act == orbc_pkg::ACT_PUSH) begin
			newest_q <= write_q;
			write_q  <= write_inc;
			if (full) begin
				oldest_q <= oldest_inc;
				fill_q   <= cap_q;
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			ncur_s1   <= ncur[orbc_pkg::CURSOR_W-1:0];
			rd_s1     <= do_read;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_status_q <= status_s1;
			out_cursor_q <= ncur_s1;
			out_word_q   <= rd_s1 ? orbc_pkg::PORT_W'(mem_rdata) : '0;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.read_word  = out_word_q;
	assign rsp.new_cursor = out_cursor_q;

	`ORBC_ASSERT(a_fill_bound, clk, arst_n, fill_q <= cap_q)
	`ORBC_ASSERT(a_pos_bound, clk, arst_n,
		write_q < cap_q && oldest_q < cap_q && newest_q < cap_q)
	`ORBC_ASSERT(a_advance_fills_out, clk, arst_n, advance |=> out_valid_q)
	`ORBC_NEVER(a_read_only_on_ok, clk, arst_n,
		valid_s1 && rd_s1 && status_s1 != orbc_pkg::ST_OK)

endmodule
`default_nettype wire

[src/orbc_ram.sv]
`default_nettype none
module orbc_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data is registered and holds until the next read.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule
`default_nettype wire
